[rtl/efa_pkg.sv]
package efa_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_FADE_DISTANCE   = 2'd2;
	localparam logic [1:0] REG_FADE_RECIPROCAL = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int SIZE_W      = 13;
	localparam int FIX_W       = 16;
	localparam int FIELD_COORD_W = 12;

	// register reset values
	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST     = 13'd64;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST    = 13'd64;
	localparam logic [FIX_W-1:0]  FADE_DISTANCE_RST   = 16'd2048;
	localparam logic [FIX_W-1:0]  FADE_RECIPROCAL_RST = 16'd8192;

	// 1.0 in q8.8, smallest fade band
	localparam logic [FIX_W-1:0] FADE_MIN = 16'd256;

	// 1.0 in q0.30
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} argb_t;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	// term divided by the series index, literal divisors only
	function automatic logic [63:0] div_by_index(input logic [63:0] term, input int k);
		logic [63:0] r;
		case (k)
			1:  r = term / 1;
			2:  r = term / 2;
			3:  r = term / 3;
			4:  r = term / 4;
			5:  r = term / 5;
			6:  r = term / 6;
			7:  r = term / 7;
			8:  r = term / 8;
			9:  r = term / 9;
			10: r = term / 10;
			11: r = term / 11;
			12: r = term / 12;
			13: r = term / 13;
			14: r = term / 14;
			15: r = term / 15;
			16: r = term / 16;
			17: r = term / 17;
			18: r = term / 18;
			19: r = term / 19;
			20: r = term / 20;
			default: r = term;
		endcase
		return r;
	endfunction

	// exp(-r) in q0.30, taylor series truncated after the 20th power, elaboration only
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] rq);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = ONE_Q30;
		pos  = ONE_Q30;
		neg  = 64'd0;
		for (int k = 1; k <= 20; k++) begin
			term = div_by_index((term * rq) >> 30, k);
			if (k % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

endpackage

[rtl/efa_dist.sv]
module efa_dist #(
	parameter int CW = 12
) (
	input  logic                          clk,
	input  efa_pkg::stage_en_t            en,
	input  logic [efa_pkg::SIZE_W-1:0]    frame_width,
	input  logic [efa_pkg::SIZE_W-1:0]    frame_height,
	input  logic [efa_pkg::FIX_W-1:0]     fade_distance,
	input  logic [efa_pkg::FIX_W-1:0]     fade_reciprocal,
	input  logic [CW-1:0]                 col,
	input  logic [CW-1:0]                 row,
	input  efa_pkg::argb_t                pix,
	output efa_pkg::argb_t                pix_s2,
	output logic                          pass_s2,
	output logic [CW+efa_pkg::FIX_W-1:0]  prod_s2
);

	localparam int CMP_W = 24;

	logic [CW-1:0]        dx_s1;
	logic [CW-1:0]        dy_s1;
	efa_pkg::argb_t       pix_s1;
	logic [CW-1:0]        d;
	logic [efa_pkg::FIX_W-1:0] fade_eff;
	logic [CMP_W-1:0]     d_shift;
	logic [CMP_W-1:0]     fade_ext;

	// distance to the nearer edge along one axis, zero outside the frame
	function automatic logic [CW-1:0] edge_dist(input logic [CW-1:0] p,
			input logic [efa_pkg::SIZE_W-1:0] size);
		logic [efa_pkg::SIZE_W-1:0] p_ext;
		logic [efa_pkg::SIZE_W-1:0] other;
		logic [CW-1:0] r;
		p_ext = {{(efa_pkg::SIZE_W-CW){1'b0}}, p};
		other = size - efa_pkg::SIZE_W'(1) - p_ext;
		if (p_ext >= size) begin
			r = '0;
		end else if (p_ext < other) begin
			r = p;
		end else begin
			r = other[CW-1:0];
		end
		return r;
	endfunction

	// stage 1: per-axis edge distance
	always_ff @(posedge clk) begin
		if (en.s1) begin
			dx_s1  <= edge_dist(col, frame_width);
			dy_s1  <= edge_dist(row, frame_height);
			pix_s1 <= pix;
		end
	end

	// nearer edge, fade band test
	always_comb begin
		d        = (dx_s1 < dy_s1) ? dx_s1 : dy_s1;
		fade_eff = (fade_distance < efa_pkg::FADE_MIN) ? efa_pkg::FADE_MIN : fade_distance;
		d_shift  = {{(CMP_W-CW-8){1'b0}}, d, 8'h00};
		fade_ext = {{(CMP_W-efa_pkg::FIX_W){1'b0}}, fade_eff};
	end

	// stage 2: band flag and d times reciprocal
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pix_s2  <= pix_s1;
			pass_s2 <= (d_shift >= fade_ext);
			prod_s2 <= {{efa_pkg::FIX_W{1'b0}}, d} * {{CW{1'b0}}, fade_reciprocal};
		end
	end

endmodule

[rtl/efa_index.sv]
module efa_index #(
	parameter int CW = 12,
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int IW = 8
) (
	input  logic                          clk,
	input  efa_pkg::stage_en_t            en,
	input  efa_pkg::argb_t                pix_s2,
	input  logic                          pass_s2,
	input  logic [CW+efa_pkg::FIX_W-1:0]  prod_s2,
	output efa_pkg::argb_t                pix_s4,
	output logic                          pass_s4,
	output logic [IW-1:0]                 idx_s4
);

	localparam int SQ_W    = 2 * efa_pkg::FIX_W;
	localparam int SCALE_W = SQ_W + IW;

	logic [efa_pkg::FIX_W-1:0] q;
	logic [SQ_W-1:0]           sq_s3;
	efa_pkg::argb_t            pix_s3;
	logic                      pass_s3;
	logic [SCALE_W-1:0]        scaled;

	// q0.16 ratio, saturated
	assign q = (|prod_s2[CW+efa_pkg::FIX_W-1:efa_pkg::FIX_W]) ? '1
		: prod_s2[efa_pkg::FIX_W-1:0];

	// stage 3: square of the ratio
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sq_s3   <= {{efa_pkg::FIX_W{1'b0}}, q} * {{efa_pkg::FIX_W{1'b0}}, q};
			pix_s3  <= pix_s2;
			pass_s3 <= pass_s2;
		end
	end

	// table position, product with the depth keeps its high bits
	assign scaled = SCALE_W'(sq_s3) * SCALE_W'(EXP_TABLE_DEPTH);

	// stage 4: table index
	always_ff @(posedge clk) begin
		if (en.s4) begin
			idx_s4  <= scaled[SQ_W +: IW];
			pix_s4  <= pix_s3;
			pass_s4 <= pass_s3;
		end
	end

endmodule

[rtl/efa_fall.sv]
module efa_fall #(
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int IW = 8
) (
	input  logic               clk,
	input  efa_pkg::stage_en_t en,
	input  efa_pkg::argb_t     pix_s4,
	input  logic               pass_s4,
	input  logic [IW-1:0]      idx_s4,
	output efa_pkg::argb_t     pix_s6,
	output logic               pass_s6,
	output logic [8:0]         k1_s6
);

	typedef logic [15:0] rom_t [EXP_TABLE_DEPTH];

	// falloff table, 1 - exp(-t) in q0.16 over t in [0, 9)
	function automatic rom_t build_rom();
		rom_t r;
		logic [63:0] e1;
		logic [63:0] m;
		logic [63:0] n;
		logic [63:0] fr;
		logic [63:0] e;
		logic [63:0] f16;
		e1 = efa_pkg::exp_neg_q30(efa_pkg::ONE_Q30);
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			m  = 64'd9 * 64'(i);
			n  = m / EXP_TABLE_DEPTH;
			fr = m % EXP_TABLE_DEPTH;
			e  = efa_pkg::exp_neg_q30((fr << 30) / EXP_TABLE_DEPTH);
			while (n > 64'd0) begin
				e = (e * e1) >> 30;
				n = n - 64'd1;
			end
			if (e > efa_pkg::ONE_Q30) begin
				e = efa_pkg::ONE_Q30;
			end
			f16 = (efa_pkg::ONE_Q30 - e + 64'd8192) >> 14;
			if (f16 > 64'd65535) begin
				f16 = 64'd65535;
			end
			r[i] = f16[15:0];
		end
		return r;
	endfunction

	localparam rom_t FALL_ROM = build_rom();

	logic [15:0]    entry_s5;
	efa_pkg::argb_t pix_s5;
	logic           pass_s5;
	logic [23:0]    k_sum;

	// stage 5: table read
	always_ff @(posedge clk) begin
		if (en.s5) begin
			entry_s5 <= FALL_ROM[idx_s4];
			pix_s5   <= pix_s4;
			pass_s5  <= pass_s4;
		end
	end

	// round to 8 bits
	assign k_sum = {8'h00, entry_s5} * 24'd255 + 24'd32768;

	// stage 6: scale factor k + 1
	always_ff @(posedge clk) begin
		if (en.s6) begin
			k1_s6   <= {1'b0, k_sum[23:16]} + 9'd1;
			pix_s6  <= pix_s5;
			pass_s6 <= pass_s5;
		end
	end

endmodule

[rtl/efa_scale.sv]
module efa_scale (
	input  logic               clk,
	input  efa_pkg::stage_en_t en,
	input  efa_pkg::argb_t     pix_s6,
	input  logic               pass_s6,
	input  logic [8:0]         k1_s6,
	output efa_pkg::argb_t     pix_s7
);

	efa_pkg::argb_t scaled;

	// (c * (k + 1)) >> 8
	function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [8:0] k1);
		logic [16:0] p;
		p = {9'd0, c} * {8'd0, k1};
		return p[15:8];
	endfunction

	always_comb begin
		scaled.alpha = scale_ch(pix_s6.alpha, k1_s6);
		scaled.red   = scale_ch(pix_s6.red, k1_s6);
		scaled.green = scale_ch(pix_s6.green, k1_s6);
		scaled.blue  = scale_ch(pix_s6.blue, k1_s6);
	end

	// stage 7: output register
	always_ff @(posedge clk) begin
		if (en.s7) begin
			pix_s7 <= pass_s6 ? pix_s6 : scaled;
		end
	end

endmodule

[rtl/edge_feather_alpha.sv]
// edge_feather_alpha: fades the border of a premultiplied argb frame.
// input channel s_*: one pixel per word, its column, row and four channels.
// output channel m_*: the four scaled channels, one word for every input word,
// in input order.
// pixels at or beyond the fade distance from every edge pass unchanged; pixels
// outside the frame come out as zero.
// config: cfg_we writes cfg_data into the register at cfg_index (0 width,
// 1 height, 2 fade distance q8.8, 3 its reciprocal q0.16); write only while
// no word is in flight.
// path: stage 1 loads at the input accept edge, m_tvalid marks a full stage 7.
// throughput: one word per clock while m_tready is high, set by the
// seven-stage pipeline (edge distance, ratio product, square, table index,
// falloff table read, rounding, channel scaling).
// stalls: each stage loads when it is empty or the stage after it moves, so
// bubbles close up and s_tready drops only when all stages hold words.
// reset: empties the pipeline and restores the register defaults (64 x 64
// frame, fade 8.0, reciprocal 1/8).
module edge_feather_alpha #(
	parameter int COORD_BITS = 12,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // pixel_col, pixel_row, in_alpha, in_red, in_green, in_blue
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_alpha, out_red, out_green, out_blue
	input  logic        cfg_we,
	input  logic [efa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [efa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = (COORD_BITS < efa_pkg::FIELD_COORD_W) ? COORD_BITS
		: efa_pkg::FIELD_COORD_W;
	localparam int IW = $clog2(EXP_TABLE_DEPTH);

	logic [efa_pkg::SIZE_W-1:0] frame_width_q;
	logic [efa_pkg::SIZE_W-1:0] frame_height_q;
	logic [efa_pkg::FIX_W-1:0]  fade_distance_q;
	logic [efa_pkg::FIX_W-1:0]  fade_reciprocal_q;

	efa_pkg::stage_en_t en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	efa_pkg::argb_t pix_in;
	efa_pkg::argb_t pix_s2, pix_s4, pix_s6, pix_s7;
	logic           pass_s2, pass_s4, pass_s6;
	logic [CW+efa_pkg::FIX_W-1:0] prod_s2;
	logic [IW-1:0]  idx_s4;
	logic [8:0]     k1_s6;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= efa_pkg::FRAME_WIDTH_RST;
			frame_height_q    <= efa_pkg::FRAME_HEIGHT_RST;
			fade_distance_q   <= efa_pkg::FADE_DISTANCE_RST;
			fade_reciprocal_q <= efa_pkg::FADE_RECIPROCAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				efa_pkg::REG_FRAME_WIDTH:     frame_width_q <= cfg_data[efa_pkg::SIZE_W-1:0];
				efa_pkg::REG_FRAME_HEIGHT:    frame_height_q <= cfg_data[efa_pkg::SIZE_W-1:0];
				efa_pkg::REG_FADE_DISTANCE:   fade_distance_q <= cfg_data;
				efa_pkg::REG_FADE_RECIPROCAL: fade_reciprocal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables, a stage moves when empty or when the next one moves
	always_comb begin
		en.s7 = !valid_s7 || m_tready;
		en.s6 = !valid_s6 || en.s7;
		en.s5 = !valid_s5 || en.s6;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign s_tready = en.s1;

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
			if (en.s7) valid_s7 <= valid_s6;
		end
	end

	// unpack input channels
	always_comb begin
		pix_in.alpha = s_tdata[31:24];
		pix_in.red   = s_tdata[39:32];
		pix_in.green = s_tdata[47:40];
		pix_in.blue  = s_tdata[55:48];
	end

	efa_dist #(
		.CW (CW)
	) u_dist (
		.clk             (clk),
		.en              (en),
		.frame_width     (frame_width_q),
		.frame_height    (frame_height_q),
		.fade_distance   (fade_distance_q),
		.fade_reciprocal (fade_reciprocal_q),
		.col             (s_tdata[CW-1:0]),
		.row             (s_tdata[efa_pkg::FIELD_COORD_W +: CW]),
		.pix             (pix_in),
		.pix_s2          (pix_s2),
		.pass_s2         (pass_s2),
		.prod_s2         (prod_s2)
	);

	efa_index #(
		.CW              (CW),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
		.IW              (IW)
	) u_index (
		.clk     (clk),
		.en      (en),
		.pix_s2  (pix_s2),
		.pass_s2 (pass_s2),
		.prod_s2 (prod_s2),
		.pix_s4  (pix_s4),
		.pass_s4 (pass_s4),
		.idx_s4  (idx_s4)
	);

	efa_fall #(
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
		.IW              (IW)
	) u_fall (
		.clk     (clk),
		.en      (en),
		.pix_s4  (pix_s4),
		.pass_s4 (pass_s4),
		.idx_s4  (idx_s4),
		.pix_s6  (pix_s6),
		.pass_s6 (pass_s6),
		.k1_s6   (k1_s6)
	);

	efa_scale u_scale (
		.clk     (clk),
		.en      (en),
		.pix_s6  (pix_s6),
		.pass_s6 (pass_s6),
		.k1_s6   (k1_s6),
		.pix_s7  (pix_s7)
	);

	// output word
	assign m_tvalid = valid_s7;
	assign m_tdata  = {pix_s7.blue, pix_s7.green, pix_s7.red, pix_s7.alpha};

	// a ready receiver keeps the whole pipeline moving
	assert property (@(posedge clk) disable iff (!arst_n) m_tready |-> s_tready)
		else $error("input stalled while output side is ready");

	// an accepted input with no output taken adds exactly one word in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !(m_tvalid && m_tready)) |=>
		($countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6,
			valid_s7}) == $past($countones({valid_s1, valid_s2, valid_s3, valid_s4,
			valid_s5, valid_s6, valid_s7})) + 1))
		else $error("pipeline occupancy lost or duplicated a word");

	// a full stalled pipeline keeps its output word
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && !s_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output word changed");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	// input word: col lowest, then row, alpha, red, green, blue
	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [11:0] row;
		logic [11:0] col;
	} pixel_word_t;

	// expected feathered pixels in stream order, with a local copy of the registers
	class feather_scoreboard;
		logic [15:0] falloff_rom [256];
		logic [12:0] width_px;
		logic [12:0] height_px;
		logic [15:0] fade_q88;
		logic [15:0] recip_q16;
		logic [31:0] expected_q [$];
		int n_in;
		int n_out;
		int n_err;
		int n_pass;
		int n_faded;
		int n_outside;

		function new();
			width_px  = efa_pkg::FRAME_WIDTH_RST;
			height_px = efa_pkg::FRAME_HEIGHT_RST;
			fade_q88  = efa_pkg::FADE_DISTANCE_RST;
			recip_q16 = efa_pkg::FADE_RECIPROCAL_RST;
			build_falloff();
		endfunction

		// exp(-r) in q0.30, series truncated after the 20th power
		function bit [63:0] decay_q30(bit [63:0] r);
			bit [63:0] term;
			bit [63:0] sum_even;
			bit [63:0] sum_odd;
			term = 64'd1 << 30;
			sum_even = term;
			sum_odd = 64'd0;
			for (int n = 1; n <= 20; n++) begin
				term = ((term * r) >> 30) / 64'(n);
				if (n % 2 == 1) sum_odd += term;
				else sum_even += term;
			end
			return (sum_even > sum_odd) ? sum_even - sum_odd : 64'd0;
		endfunction

		// falloff table: 1 - exp(-t) in q0.16 at t = 9*i/256
		function void build_falloff();
			bit [63:0] one;
			bit [63:0] inv_e;
			bit [63:0] whole;
			bit [63:0] frac;
			bit [63:0] e;
			bit [63:0] f;
			one = 64'd1 << 30;
			inv_e = decay_q30(one);
			for (int i = 0; i < 256; i++) begin
				whole = 64'((9 * i) / 256);
				frac = 64'((9 * i) % 256);
				e = decay_q30((frac << 30) / 64'd256);
				while (whole > 64'd0) begin
					e = (e * inv_e) >> 30;
					whole--;
				end
				if (e > one) e = one;
				f = (one - e + 64'd8192) >> 14;
				if (f > 64'd65535) f = 64'd65535;
				falloff_rom[i] = f[15:0];
			end
		endfunction

		function void set_reg(logic [efa_pkg::CFG_INDEX_W-1:0] idx,
				logic [efa_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				efa_pkg::REG_FRAME_WIDTH:     width_px  = data[12:0];
				efa_pkg::REG_FRAME_HEIGHT:    height_px = data[12:0];
				efa_pkg::REG_FADE_DISTANCE:   fade_q88  = data;
				efa_pkg::REG_FADE_RECIPROCAL: recip_q16 = data;
				default: ;
			endcase
		endfunction

		// distance to the nearer edge along one axis, zero outside
		function bit [63:0] edge_gap(bit [63:0] p, bit [63:0] size);
			bit [63:0] far_side;
			if (p >= size) return 64'd0;
			far_side = size - 64'd1 - p;
			return (p < far_side) ? p : far_side;
		endfunction

		function void note_pixel(pixel_word_t px);
			bit [63:0] dx;
			bit [63:0] dy;
			bit [63:0] d;
			bit [63:0] band;
			bit [63:0] q;
			bit [63:0] idx;
			bit [63:0] k;
			bit [63:0] c;
			logic [31:0] w;
			bit [7:0] chan [4];
			chan[0] = px.alpha;
			chan[1] = px.red;
			chan[2] = px.green;
			chan[3] = px.blue;
			dx = edge_gap(64'(px.col), 64'(width_px));
			dy = edge_gap(64'(px.row), 64'(height_px));
			d = (dx < dy) ? dx : dy;
			band = (fade_q88 < efa_pkg::FADE_MIN) ? 64'(efa_pkg::FADE_MIN) : 64'(fade_q88);
			if (px.col >= width_px || px.row >= height_px) n_outside++;
			if ((d << 8) >= band) begin
				n_pass++;
				for (int j = 0; j < 4; j++) w[8*j +: 8] = chan[j];
			end else begin
				n_faded++;
				q = d * 64'(recip_q16);
				if (q > 64'd65535) q = 64'd65535;
				idx = (q * q * 64'd256) >> 32;
				if (idx > 64'd255) idx = 64'd255;
				k = (64'(falloff_rom[idx[7:0]]) * 64'd255 + 64'd32768) >> 16;
				for (int j = 0; j < 4; j++) begin
					c = 64'(chan[j]);
					c = (c * (k + 64'd1)) >> 8;
					w[8*j +: 8] = c[7:0];
				end
			end
			expected_q.push_back(w);
			n_in++;
		endfunction

		function void check_word(logic [31:0] got);
			logic [31:0] want;
			string names [4];
			names = '{"out_alpha", "out_red", "out_green", "out_blue"};
			n_out++;
			if (expected_q.size() == 0) begin
				$error("output word %0h with no pixel pending", got);
				n_err++;
				return;
			end
			want = expected_q.pop_front();
			for (int j = 0; j < 4; j++) begin
				if (got[8*j +: 8] !== want[8*j +: 8]) begin
					$error("%s: expected %0d, got %0d", names[j], want[8*j +: 8],
						got[8*j +: 8]);
					n_err++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [55:0]            s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [31:0]            m_tdata;
	logic                   cfg_we = 1'b0;
	logic [efa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [efa_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	feather_scoreboard sb = new();
	bit quiet = 1'b0;

	// register settings per phase, phase 0 runs on the reset values
	int setup_w [9]     = '{64, 4096, 1, 0, 640, 100, 4096, 3, 64};
	int setup_h [9]     = '{64, 4096, 1, 0, 480, 37, 2, 4096, 64};
	int setup_fade [9]  = '{2048, 65535, 256, 2048, 0, 4000, 12800, 1000, 2048};
	int setup_recip [9] = '{8192, 256, 65535, 8192, 0, 65535, 1311, 16777, 8192};

	edge_feather_alpha uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata);
	end

	// receiver: random stalls, one long hold-off once 300 pixels have been sent
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && sb.n_in >= 300) begin
				held = 1'b1;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (79) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 9);
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic pixel_word_t make_pixel(int col, int row, int a, int r, int g, int b);
		pixel_word_t px;
		px.col = col[11:0];
		px.row = row[11:0];
		px.alpha = a[7:0];
		px.red = r[7:0];
		px.green = g[7:0];
		px.blue = b[7:0];
		return px;
	endfunction

	// coordinate biased toward the fade bands, sometimes outside the frame
	function automatic logic [11:0] pick_coord(int size, int band);
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom_range(0, band);
			4, 5, 6: v = (size > band) ? size - 1 - $urandom_range(0, band)
				: $urandom_range(0, (size > 0) ? size - 1 : 0);
			7: v = $urandom;
			8: v = (size <= 4095) ? $urandom_range(size, 4095) : $urandom;
			default: v = (size > 0) ? $urandom_range(0, size - 1) : $urandom;
		endcase
		return v[11:0];
	endfunction

	function automatic int pick_channel();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic send_pixel(input pixel_word_t px);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(px);
	endtask

	// stop offering and wait for every pending pixel to come out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [efa_pkg::CFG_INDEX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[efa_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, value[efa_pkg::CFG_DATA_W-1:0]);
	endtask

	// main sequence
	initial begin
		int band;
		int per_phase;
		per_phase = 82;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pixels on the 64 x 64 reset frame, fade 8.0
		send_pixel(make_pixel(0, 0, 255, 255, 255, 255));
		send_pixel(make_pixel(63, 63, 255, 255, 255, 255));
		send_pixel(make_pixel(32, 32, 255, 255, 255, 255));
		send_pixel(make_pixel(32, 32, 0, 0, 0, 0));
		send_pixel(make_pixel(8, 8, 200, 100, 50, 25));
		send_pixel(make_pixel(7, 7, 200, 100, 50, 25));
		send_pixel(make_pixel(7, 40, 255, 0, 255, 0));
		send_pixel(make_pixel(40, 1, 0, 255, 0, 255));
		send_pixel(make_pixel(55, 30, 255, 255, 255, 255));
		send_pixel(make_pixel(56, 30, 255, 255, 255, 255));
		send_pixel(make_pixel(64, 10, 255, 255, 255, 255));
		send_pixel(make_pixel(10, 64, 255, 255, 255, 255));
		send_pixel(make_pixel(4095, 4095, 255, 255, 255, 255));
		send_pixel(make_pixel(12'haaa, 12'h555, 170, 85, 170, 85));
		send_pixel(make_pixel(12'h555, 12'haaa, 85, 170, 85, 170));
		send_pixel(make_pixel(4, 4, 255, 0, 0, 0));
		send_pixel(make_pixel(3, 50, 128, 64, 32, 16));
		send_pixel(make_pixel(6, 6, 1, 2, 4, 8));
		send_pixel(make_pixel(5, 30, 128, 64, 32, 16));
		send_pixel(make_pixel(1, 1, 255, 128, 127, 1));

		for (int p = 0; p < 9; p++) begin
			if (p > 0) begin
				drain();
				write_reg(efa_pkg::REG_FRAME_WIDTH, setup_w[p]);
				write_reg(efa_pkg::REG_FRAME_HEIGHT, setup_h[p]);
				write_reg(efa_pkg::REG_FADE_DISTANCE, setup_fade[p]);
				write_reg(efa_pkg::REG_FADE_RECIPROCAL, setup_recip[p]);
				@(negedge clk);
				cfg_we <= 1'b0;
			end
			quiet = (p == 8);
			band = (setup_fade[p] >> 8) + 2;
			for (int i = 0; i < per_phase; i++) begin
				// in phase 2, one pause mid-phase until the pipeline is empty
				if (p == 2 && i == per_phase / 2) drain();
				send_pixel(make_pixel(pick_coord(setup_w[p], band),
					pick_coord(setup_h[p], band), pick_channel(), pick_channel(),
					pick_channel(), pick_channel()));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("checked %0d of %0d pixels over 9 register settings", sb.n_out, sb.n_in);
		$display("%0d faded, %0d passed through, %0d outside the frame",
			sb.n_faded, sb.n_pass, sb.n_outside);
		if (sb.n_err == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
